// ===== rtl/mbp_pkg.sv =====
package mbp_pkg;

	localparam int BYTE_W  = 8;
	localparam int PEND_W  = 7;
	localparam int VALUE_W = 64;
	localparam int COUNT_W = 7;
	localparam int BUF_W   = 72;
	localparam int NBYTE_W = 4;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef logic [1:0] step_t;

	localparam step_t STEP_WAIT  = 2'd0;
	localparam step_t STEP_CHECK = 2'd1;
	localparam step_t STEP_EMIT  = 2'd2;
	localparam step_t STEP_SAVE  = 2'd3;

	typedef logic [1:0] cond_t;

	localparam cond_t COND_ALWAYS   = 2'd0;
	localparam cond_t COND_NO_IN    = 2'd1;
	localparam cond_t COND_NO_BYTES = 2'd2;
	localparam cond_t COND_MORE     = 2'd3;

	typedef struct packed {
		logic  take_in;
		logic  give_out;
		logic  save;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_beat;
		logic out_beat;
		logic no_bytes;
		logic last_byte;
	} seq_flags_t;

endpackage

// ===== rtl/mbp_ctrl_rom.sv =====
module mbp_ctrl_rom (
	input  mbp_pkg::step_t      step,
	output mbp_pkg::ctrl_word_t word
);

	// take_in, give_out, save, jump condition, jump target
	always_comb begin
		case (step)
			mbp_pkg::STEP_WAIT: begin
				word = '{1'b1, 1'b0, 1'b0, mbp_pkg::COND_NO_IN, mbp_pkg::STEP_WAIT};
			end
			mbp_pkg::STEP_CHECK: begin
				word = '{1'b0, 1'b0, 1'b0, mbp_pkg::COND_NO_BYTES, mbp_pkg::STEP_SAVE};
			end
			mbp_pkg::STEP_EMIT: begin
				word = '{1'b0, 1'b1, 1'b0, mbp_pkg::COND_MORE, mbp_pkg::STEP_EMIT};
			end
			mbp_pkg::STEP_SAVE: begin
				word = '{1'b0, 1'b0, 1'b1, mbp_pkg::COND_ALWAYS, mbp_pkg::STEP_WAIT};
			end
			default: begin
				word = '{1'b0, 1'b0, 1'b0, mbp_pkg::COND_ALWAYS, mbp_pkg::STEP_WAIT};
			end
		endcase
	end

endmodule

// ===== rtl/mbp_sequencer.sv =====
module mbp_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  mbp_pkg::seq_flags_t flags,
	output mbp_pkg::ctrl_word_t ctrl
);

	mbp_pkg::step_t step_q;
	mbp_pkg::step_t step_d;
	logic           jump;

	mbp_ctrl_rom u_rom (
		.step (step_q),
		.word (ctrl)
	);

	always_comb begin
		case (ctrl.cond)
			mbp_pkg::COND_ALWAYS:   jump = 1'b1;
			mbp_pkg::COND_NO_IN:    jump = !flags.in_beat;
			mbp_pkg::COND_NO_BYTES: jump = flags.no_bytes;
			mbp_pkg::COND_MORE:     jump = !(flags.out_beat && flags.last_byte);
			default:                jump = 1'b1;
		endcase
	end

	assign step_d = jump ? ctrl.target : mbp_pkg::step_t'(step_q + 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mbp_pkg::STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== rtl/mbp_datapath.sv =====
module mbp_datapath #(
	parameter int MAX_FIELD_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mbp_pkg::ctrl_word_t                 ctrl,
	input  logic                                in_beat,
	input  logic                                out_beat,
	input  logic                                kind,
	input  logic [mbp_pkg::VALUE_W-1:0]         field_value,
	input  logic [mbp_pkg::COUNT_W-1:0]         bit_count,
	output logic [mbp_pkg::BYTE_W-1:0]          out_byte,
	output logic                                last_of_run,
	output logic                                no_bytes,
	output logic                                last_byte
);

	localparam logic [mbp_pkg::COUNT_W-1:0] MAX_CNT = mbp_pkg::COUNT_W'(MAX_FIELD_BITS);

	logic [mbp_pkg::BUF_W-1:0]   buf_q;
	logic [mbp_pkg::NBYTE_W-1:0] nbytes_q;
	logic [2:0]                  rem_q;
	logic [mbp_pkg::PEND_W-1:0]  pend_bits_q;
	logic [2:0]                  pend_cnt_q;

	logic [mbp_pkg::COUNT_W-1:0] cnt_eff;
	logic [mbp_pkg::VALUE_W-1:0] val_left;
	logic [mbp_pkg::BUF_W-1:0]   pend_part;
	logic [mbp_pkg::BUF_W-1:0]   val_part;
	logic [mbp_pkg::COUNT_W-1:0] total;
	logic [mbp_pkg::NBYTE_W-1:0] nbytes_d;
	logic [2:0]                  rem_d;

	always_comb begin
		if (kind == mbp_pkg::KIND_FLUSH) begin
			cnt_eff = '0;
		end else if (bit_count > MAX_CNT) begin
			cnt_eff = MAX_CNT;
		end else begin
			cnt_eff = bit_count;
		end
	end

	// left-align pending bits, then the field bits right behind them
	assign val_left  = field_value << (mbp_pkg::COUNT_W'(mbp_pkg::VALUE_W) - cnt_eff);
	assign pend_part = {pend_bits_q, {(mbp_pkg::BUF_W - mbp_pkg::PEND_W){1'b0}}}
		<< (3'd7 - pend_cnt_q);
	assign val_part  = {val_left, {(mbp_pkg::BUF_W - mbp_pkg::VALUE_W){1'b0}}} >> pend_cnt_q;
	assign total     = mbp_pkg::COUNT_W'(pend_cnt_q) + cnt_eff;

	always_comb begin
		if (kind == mbp_pkg::KIND_FLUSH) begin
			nbytes_d = (pend_cnt_q != 3'd0) ? mbp_pkg::NBYTE_W'(1) : '0;
			rem_d    = 3'd0;
		end else begin
			nbytes_d = total[mbp_pkg::COUNT_W-1:3];
			rem_d    = total[2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take_in && in_beat) begin
			buf_q <= pend_part | val_part;
		end else if (ctrl.give_out && out_beat) begin
			buf_q <= buf_q << mbp_pkg::BYTE_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbytes_q    <= '0;
			rem_q       <= '0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else begin
			if (ctrl.take_in && in_beat) begin
				nbytes_q <= nbytes_d;
				rem_q    <= rem_d;
			end else if (ctrl.give_out && out_beat) begin
				nbytes_q <= nbytes_q - mbp_pkg::NBYTE_W'(1);
			end
			// leftover bits sit at the top of the buffer; right-align them
			if (ctrl.save) begin
				pend_bits_q <= buf_q[mbp_pkg::BUF_W-1 -: mbp_pkg::PEND_W] >> (3'd7 - rem_q);
				pend_cnt_q  <= rem_q;
			end
		end
	end

	assign out_byte    = buf_q[mbp_pkg::BUF_W-1 -: mbp_pkg::BYTE_W];
	assign no_bytes    = (nbytes_q == '0);
	assign last_byte   = (nbytes_q == mbp_pkg::NBYTE_W'(1));
	assign last_of_run = last_byte;

endmodule

// ===== rtl/msb_first_bit_packer.sv =====
// MSB-first bit packer.
// Input channel (in_valid / in_stall): one beat is either a write (kind 0)
// carrying field_value and bit_count, or a flush (kind 1). A write appends
// the low bit_count bits of field_value, most significant first; counts above
// MAX_FIELD_BITS saturate. A flush pads pending bits with zeros on the right.
// Output channel (out_valid / out_stall): one beat per completed byte, first
// bit in the MSB, with last_of_run set on the final byte of an input beat.
// Items are handled one at a time by a four-step control program. The first
// byte is presented once the program has passed from its wait step through
// its check step; the item then ends in the save step. The byte rate, one
// per cycle while out_stall is low, is set by the single emit step of the
// program.
// While out_stall is high the emit step holds and the byte does not change.
// Reset clears the pending bits and returns the program to its wait step.
module msb_first_bit_packer #(
	parameter int MAX_FIELD_BITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [mbp_pkg::VALUE_W-1:0] field_value,
	input  logic [mbp_pkg::COUNT_W-1:0] bit_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mbp_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last_of_run
);

	mbp_pkg::ctrl_word_t ctrl;
	mbp_pkg::seq_flags_t flags;

	assign in_stall       = !ctrl.take_in;
	assign out_valid      = ctrl.give_out;
	assign flags.in_beat  = in_valid && !in_stall;
	assign flags.out_beat = out_valid && !out_stall;

	mbp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	mbp_datapath #(
		.MAX_FIELD_BITS (MAX_FIELD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.in_beat     (flags.in_beat),
		.out_beat    (flags.out_beat),
		.kind        (kind),
		.field_value (field_value),
		.bit_count   (bit_count),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.no_bytes    (flags.no_bytes),
		.last_byte   (flags.last_byte)
	);

`ifndef ASSERT_OFF
	a_one_side_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a byte is presented");

	a_no_direct_out: assert property (@(posedge clk) disable iff (!arst_n)
		flags.in_beat |=> !out_valid)
		else $error("byte presented right after an input beat");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(flags.out_beat && last_of_run) |=> !out_valid)
		else $error("bytes continue past the last of a run");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(flags.out_beat && !last_of_run) |=> out_valid)
		else $error("run stopped before its last byte");
`endif

endmodule
